[hdl/smpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the sorted max priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int VALUE_WIDTH      = 32;
   localparam int OCC_WIDTH        = 5;

   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                        kind;
      logic signed [VALUE_WIDTH-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                      status;
      logic signed [VALUE_WIDTH-1:0]   popped;
      logic [OCC_WIDTH-1:0]            occupancy;
   } rsp_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic                            push;
      logic                            pop;
      logic signed [VALUE_WIDTH-1:0]   value;
   } cell_ctl_type;

endpackage

[hdl/smpq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: holds a value, compares it against the pushed
// value and takes its left neighbor, the new value or its right neighbor.
// ----------------------------------------------------------------------------
module smpq_cell
   import smpq_pkg::*;
(
   input  logic                          clock,
   input  cell_ctl_type                  ctl,
   input  logic                          occupied,
   input  logic signed [VALUE_WIDTH-1:0] left_value,
   input  logic                          left_ge,
   input  logic signed [VALUE_WIDTH-1:0] right_value,
   output logic signed [VALUE_WIDTH-1:0] value,
   output logic                          ge
);

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;

   // stored entry stays ahead of the new value, ties included
   assign ge    = occupied && (value_ff >= ctl.value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.push) begin
         if (!ge) begin
            value_in = left_ge ? ctl.value : left_value;
         end
      end else if (ctl.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[hdl/sorted_max_priority_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_core
// Priority queue kept as a row of sorted cells, largest value first.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_data: kind, value) is taken on a clock edge where
//   start is high and busy is low. busy is always low here: every cell
//   compares and shifts in the same cycle, so one push or pop is taken on
//   every clock.
//   Each request gives exactly one registered response beat in the next
//   cycle: rsp_valid is high for a single cycle with status, popped value
//   and occupancy. One beat is taken per cycle; the compare in each
//   cell plus the shift mux sets the cycle.
//   A push into a full queue is dropped with status full; a pop from an
//   empty queue returns status empty and value 0.
//   The receiver cannot stall; results must be captured when rsp_valid is
//   high. Synchronous reset empties the queue and clears rsp_valid; cell
//   contents are not cleared, since slots past the count are never read.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_core
   import smpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CountWidth = $clog2(CAPACITY + 1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   cell_ctl_type                  ctl;
   logic                          accept;
   logic                          full;
   logic                          empty;
   logic                          push_ok;
   logic                          pop_ok;
   logic [CountWidth+OCC_WIDTH-1:0] count_ext;

   logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic                          cell_ge    [CAPACITY];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign full    = (count_ff == CountWidth'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign push_ok = accept && (req_data.kind == KIND_PUSH) && !full;
   assign pop_ok  = accept && (req_data.kind == KIND_POP) && !empty;

   assign ctl.push  = push_ok;
   assign ctl.pop   = pop_ok;
   assign ctl.value = req_data.value;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [VALUE_WIDTH-1:0] left_value;
         logic                          left_ge;
         logic signed [VALUE_WIDTH-1:0] right_value;

         if (i == 0) begin : g_head
            // head cell sees the new value as its left neighbor
            assign left_value = req_data.value;
            assign left_ge    = 1'b0;
         end else begin : g_body
            assign left_value = cell_value[i-1];
            assign left_ge    = cell_ge[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign right_value = cell_value[i];
         end else begin : g_mid
            assign right_value = cell_value[i+1];
         end

         smpq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (CountWidth'(i) < count_ff),
            .left_value  (left_value),
            .left_ge     (left_ge),
            .right_value (right_value),
            .value       (cell_value[i]),
            .ge          (cell_ge[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign count_ext = {{OCC_WIDTH{1'b0}}, count_in};

   always_comb begin
      rsp_data_in.status    = STATUS_DONE;
      rsp_data_in.popped    = '0;
      rsp_data_in.occupancy = count_ext[OCC_WIDTH-1:0];
      unique case (req_data.kind)
         KIND_PUSH: begin
            if (full) begin
               rsp_data_in.status = STATUS_FULL;
            end
         end
         KIND_POP: begin
            if (empty) begin
               rsp_data_in.status = STATUS_EMPTY;
            end else begin
               rsp_data_in.popped = cell_value[0];
            end
         end
         default: begin
            rsp_data_in.status = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sorted max priority queue one request beat at a time. A
// scoreboard keeps its own ordered copy of the queue, so every response beat
// is checked for status, popped value and occupancy. A short table covers
// the extremes, empty and full; random fill and drain bursts follow, with the
// sender idling at several rates.
// ----------------------------------------------------------------------------
module tb_top;
   import smpq_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEFAULT;
   localparam int PHASE_ITEMS = 300;
   localparam int DRAIN_LIMIT = 1000;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct {
      req_type op;
      bit      pinned;
      rsp_type rsp;
   } vector_row;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // typed-in response for the beat on req_data, used instead of the scoreboard
   logic    pinned_valid;
   rsp_type pinned_rsp;

   logic signed [VALUE_WIDTH-1:0] sorted_vals[$];
   rsp_type                       expected_rsps[$];
   vector_row                     vectors[$];
   int                            error_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sorted_max_priority_queue_core #(
      .CAPACITY (CAPACITY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // applies one operation to the ordered copy and returns its response
   function automatic rsp_type apply_op(req_type op);
      rsp_type r;
      int      pos;
      r.status = STATUS_DONE;
      r.popped = '0;
      if (op.kind == KIND_PUSH) begin
         if (sorted_vals.size() >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            // equal values go behind the ones already stored
            pos = 0;
            while (pos < sorted_vals.size() && sorted_vals[pos] >= op.value) pos++;
            sorted_vals.insert(pos, op.value);
         end
      end else begin
         if (sorted_vals.size() == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.popped = sorted_vals.pop_front();
         end
      end
      r.occupancy = OCC_WIDTH'(sorted_vals.size());
      return r;
   endfunction

   function automatic void add_row(kind_type k, logic signed [VALUE_WIDTH-1:0] v,
                                   bit pin = 1'b0, status_type s = STATUS_DONE,
                                   logic signed [VALUE_WIDTH-1:0] p = '0, int occ = 0);
      vector_row row;
      row.op.kind       = k;
      row.op.value      = v;
      row.pinned        = pin;
      row.rsp.status    = s;
      row.rsp.popped    = p;
      row.rsp.occupancy = OCC_WIDTH'(occ);
      vectors.push_back(row);
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2, 3, 4: return $signed($urandom_range(0, 8)) - 4;  // lots of equal values
         5:       return $urandom_range(0, 1) ? '0 : '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_op(int push_pct);
      req_type op;
      op.kind  = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
      op.value = pick_value();
      return op;
   endfunction

   task automatic send_beat(req_type op, bit pin, rsp_type pin_rsp);
      @(negedge clock);
      start        <= 1'b1;
      req_data     <= op;
      pinned_valid <= pin;
      pinned_rsp   <= pin_rsp;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_cycle();
      @(negedge clock);
      start        <= 1'b0;
      req_data     <= req_type'({1'($urandom_range(0, 1)), $urandom});
      pinned_valid <= 1'b0;
   endtask

   // scoreboard: check the response beat first, then record the accepted request
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("response beat with nothing expected: status %0d popped %0d occupancy %0d",
                      rsp_data.status, rsp_data.popped, rsp_data.occupancy);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.popped !== want.popped) begin
                  $error("popped mismatch: expected %0d, got %0d", want.popped, rsp_data.popped);
                  error_count++;
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  $error("occupancy mismatch: expected %0d, got %0d",
                         want.occupancy, rsp_data.occupancy);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            want = apply_op(req_data);
            if (pinned_valid) want = pinned_rsp;
            expected_rsps.push_back(want);
         end
      end
   end

   initial begin
      int gap_pct[4];
      int burst_left;
      int push_pct;
      int wait_cycles;

      start        = 1'b0;
      req_data     = '0;
      pinned_valid = 1'b0;
      pinned_rsp   = '0;
      reset        = 1'b1;
      gap_pct      = '{0, 48, 16, 48};
      burst_left   = 0;
      push_pct     = 50;

      // empty, extremes, equal values, fill to full, push on full, pop, refill, push on full
      add_row(KIND_POP,  32'sd5,       1'b1, STATUS_EMPTY, '0, 0);
      add_row(KIND_PUSH, VALUE_MAX,    1'b1, STATUS_DONE,  '0, 1);
      add_row(KIND_PUSH, VALUE_MIN,    1'b1, STATUS_DONE,  '0, 2);
      add_row(KIND_PUSH, 32'sd5);
      add_row(KIND_PUSH, 32'sd5);
      add_row(KIND_PUSH, -32'sd1);
      add_row(KIND_PUSH, 32'sd0);
      add_row(KIND_PUSH, 32'sd1);
      add_row(KIND_PUSH, 32'sd2);
      add_row(KIND_PUSH, 32'sd5);
      add_row(KIND_PUSH, -32'sd2);
      add_row(KIND_PUSH, 32'sd100);
      add_row(KIND_PUSH, -32'sd100);
      add_row(KIND_PUSH, 32'sh4000_0000);
      add_row(KIND_PUSH, -32'sh4000_0000);
      add_row(KIND_PUSH, 32'sd7);
      add_row(KIND_PUSH, 32'sd7);
      add_row(KIND_PUSH, 32'sd3,       1'b1, STATUS_FULL,  '0, CAPACITY);
      add_row(KIND_POP,  '0,           1'b1, STATUS_DONE,  VALUE_MAX, CAPACITY - 1);
      add_row(KIND_PUSH, 32'sd3);
      add_row(KIND_PUSH, 32'sd9,       1'b1, STATUS_FULL,  '0, CAPACITY);
      add_row(KIND_POP,  '1);

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (vectors[i]) send_beat(vectors[i].op, vectors[i].pinned, vectors[i].rsp);

      // fill and drain bursts walk the queue between empty and full
      for (int phase = 0; phase < 4; phase++) begin
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(4, 24);
               case ($urandom_range(0, 2))
                  0:       push_pct = 85;
                  1:       push_pct = 15;
                  default: push_pct = 50;
               endcase
            end
            burst_left--;
            while ($urandom_range(0, 99) < gap_pct[phase]) idle_cycle();
            send_beat(random_op(push_pct), 1'b0, '0);
         end
      end

      idle_cycle();
      for (wait_cycles = 0; expected_rsps.size() != 0 && wait_cycles < DRAIN_LIMIT;
           wait_cycles++) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         $error("%0d expected response beats never arrived", expected_rsps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
